[hdl/stream_fixed_string_replacer_top_macros.svh]
// assertion helpers, clocked on clk_i and quiet during reset
`ifndef STREAM_FIXED_STRING_REPLACER_TOP_MACROS_SVH
`define STREAM_FIXED_STRING_REPLACER_TOP_MACROS_SVH

// same-cycle implication
`define SFSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sfsr_pkg.sv]
package sfsr_pkg;

  localparam int PATTERN_LEN_DEF = 19;
  localparam int REPLACE_LEN_DEF = 14;
  localparam int TABLE_MAX       = 64;
  localparam int TABLE_IDX_W     = $clog2(TABLE_MAX);

  // search text, position 0 is the oldest byte of the window
  localparam logic [7:0] FIND_TEXT [TABLE_MAX] = '{
    0: 8'h38, 1: 8'h2E, 2: 8'h31, 3: 8'h33, 4: 8'h38, 5: 8'h2E, 6: 8'h32,
    7: 8'h31, 8: 8'h34, 9: 8'h2E, 10: 8'h31, 11: 8'h32, 12: 8'h33,
    13: 8'h3A, 14: 8'h32, 15: 8'h32, 16: 8'h32, 17: 8'h32, 18: 8'h32,
    default: 8'h00
  };

  // substitute text, sent in index order
  localparam logic [7:0] REPL_TEXT [TABLE_MAX] = '{
    0: 8'h31, 1: 8'h32, 2: 8'h37, 3: 8'h2E, 4: 8'h30, 5: 8'h2E, 6: 8'h30,
    7: 8'h2E, 8: 8'h31, 9: 8'h3A, 10: 8'h37, 11: 8'h38, 12: 8'h36,
    13: 8'h30,
    default: 8'h00
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
  } out_req_t;

  // per-cycle command to every cell of the window
  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // what the sequencer needs to see of the window
  typedef struct packed {
    logic       head_valid;
    logic [7:0] head_byte;
    logic       next_present;
    logic       full;
    logic       match;
  } win_status_t;

endpackage

[hdl/stream_fixed_string_replacer_top.sv]
// Streaming find-and-replace over a byte stream. Each request carries one byte and an
// end-of-message flag; every non-overlapping, leftmost-first occurrence of the fixed
// search text becomes the fixed substitute text, and all other bytes pass through in
// order with up to PATTERN_LEN-1 bytes held back in a row of shift cells. One request
// is taken per clock while the output side keeps up and no replacement or flush is
// under way: a byte that yields no result or one result does not hold input. A match
// sends the first substitute byte and then holds input while the rest goes out. An
// end-of-message flag sends one byte and then holds input while each byte still held
// goes out. The single output register sets the pace of the output. run_last marks the
// final result of a request, message_end the final byte of a message.
module stream_fixed_string_replacer_top #(
  parameter int PATTERN_LEN = sfsr_pkg::PATTERN_LEN_DEF,
  parameter int REPLACE_LEN = sfsr_pkg::REPLACE_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sfsr_pkg::in_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfsr_pkg::out_req_t out_data_o
);

  sfsr_pkg::cell_ctrl_t  ctrl;
  sfsr_pkg::win_status_t status;

  logic [PATTERN_LEN-1:0] cell_valid;
  logic [PATTERN_LEN:0]   win_valid;
  logic [7:0]             win_byte [PATTERN_LEN+1];
  logic [PATTERN_LEN-1:0] eq;

  assign win_valid[PATTERN_LEN] = 1'b0;
  assign win_byte[PATTERN_LEN]  = 8'h00;

  for (genvar i = 0; i < PATTERN_LEN; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
    end

    sfsr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .byte_i       (in_data_i.data_byte),
      .pat_i        (sfsr_pkg::FIND_TEXT[i]),
      .prev_valid_i (prev_valid),
      .up_byte_i    (win_byte[i+1]),
      .up_valid_i   (win_valid[i+1]),
      .valid_o      (cell_valid[i]),
      .win_byte_o   (win_byte[i]),
      .win_valid_o  (win_valid[i]),
      .eq_o         (eq[i])
    );
  end

  // the window is complete once the incoming byte fills the last cell
  assign status = '{
    head_valid:   cell_valid[0],
    head_byte:    win_byte[0],
    next_present: win_valid[1],
    full:         win_valid[PATTERN_LEN-1],
    match:        win_valid[PATTERN_LEN-1] & (&eq)
  };

  sfsr_seq #(
    .REPLACE_LEN (REPLACE_LEN)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

endmodule

[hdl/sfsr_cell.sv]
module sfsr_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfsr_pkg::cell_ctrl_t  ctrl_i,
  input  logic [7:0]            byte_i,
  input  logic [7:0]            pat_i,
  input  logic                  prev_valid_i,
  input  logic [7:0]            up_byte_i,
  input  logic                  up_valid_i,
  output logic                  valid_o,
  output logic [7:0]            win_byte_o,
  output logic                  win_valid_o,
  output logic                  eq_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       slot;

  // the new byte lands in the first empty cell
  assign slot        = ctrl_i.load & prev_valid_i & ~valid_q;
  assign win_byte_o  = slot ? byte_i : data_q;
  assign win_valid_o = valid_q | slot;
  assign eq_o        = (win_byte_o == pat_i);
  assign valid_o     = valid_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    priority if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      valid_d = up_valid_i;
      data_d  = up_byte_i;
    end else if (slot) begin
      valid_d = 1'b1;
      data_d  = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

[hdl/sfsr_seq.sv]
`include "stream_fixed_string_replacer_top_macros.svh"

module sfsr_seq #(
  parameter int REPLACE_LEN = sfsr_pkg::REPLACE_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sfsr_pkg::in_req_t      in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sfsr_pkg::out_req_t     out_data_o,
  input  sfsr_pkg::win_status_t  status_i,
  output sfsr_pkg::cell_ctrl_t   ctrl_o
);

  localparam int IdxW = sfsr_pkg::TABLE_IDX_W;
  localparam logic [IdxW-1:0] IdxOne  = IdxW'(1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(REPLACE_LEN - 1);
  localparam logic            RepOneByte = (REPLACE_LEN == 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_REPL  = 3'b010,
    ST_FLUSH = 3'b100
  } seq_state_e;

  seq_state_e         state_q, state_d;
  logic [IdxW-1:0]    repl_idx_q, repl_idx_d;
  logic               eom_q, eom_d;
  logic               out_valid_q;
  sfsr_pkg::out_req_t out_q, out_d;
  logic               can_push, accept, push, shift, last;

  assign can_push   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~((state_q == ST_IDLE) & can_push);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d    = state_q;
    repl_idx_d = repl_idx_q;
    eom_d      = eom_q;
    out_d      = out_q;
    push       = 1'b0;
    shift      = 1'b0;
    last       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.match) begin
            push  = 1'b1;
            last  = RepOneByte;
            out_d = '{out_byte: sfsr_pkg::REPL_TEXT[0], run_last: last,
                      message_end: in_data_i.end_of_message & last};
            eom_d      = in_data_i.end_of_message;
            repl_idx_d = IdxOne;
            if (!last) state_d = ST_REPL;
          end else if (status_i.full || in_data_i.end_of_message) begin
            push  = 1'b1;
            shift = 1'b1;
            last  = ~in_data_i.end_of_message | ~status_i.next_present;
            out_d = '{out_byte: status_i.head_byte, run_last: last,
                      message_end: in_data_i.end_of_message & last};
            if (!last) state_d = ST_FLUSH;
          end
        end
      end
      ST_REPL: begin
        if (can_push) begin
          push  = 1'b1;
          last  = (repl_idx_q == IdxLast);
          out_d = '{out_byte: sfsr_pkg::REPL_TEXT[repl_idx_q], run_last: last,
                    message_end: eom_q & last};
          repl_idx_d = repl_idx_q + IdxOne;
          if (last) state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          push  = 1'b1;
          shift = 1'b1;
          last  = ~status_i.next_present;
          out_d = '{out_byte: status_i.head_byte, run_last: last, message_end: last};
          if (last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ctrl_o = '{load: accept, shift: shift, clear: accept & status_i.match};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      repl_idx_q  <= '0;
      eom_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      repl_idx_q <= repl_idx_d;
      eom_q      <= eom_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SFSR_ASSERT_IMP(a_repl_window_empty, state_q == ST_REPL, !status_i.head_valid, "window not empty during replacement")
  `SFSR_ASSERT_IMP(a_flush_has_data, state_q == ST_FLUSH, status_i.head_valid, "flush with empty window")
  `SFSR_ASSERT_IMP(a_repl_idx_range, state_q == ST_REPL, repl_idx_q <= IdxLast, "replacement index past end")
  `SFSR_ASSERT_NXT(a_repl_done_idle, (state_q == ST_REPL) && push && last, state_q == ST_IDLE, "replacement did not return to idle")

endmodule
